// ===== sv/multichannel_pulse_tachometer_assert.svh =====
// assertion macros for the tachometer block
// used by the top level; needs a clock and an active-high reset name as arguments
`ifndef MULTICHANNEL_PULSE_TACHOMETER_ASSERT_SVH
`define MULTICHANNEL_PULSE_TACHOMETER_ASSERT_SVH

// same-cycle implication
`define MPT_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("tachometer check failed: same-cycle implication");

// next-cycle implication
`define MPT_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("tachometer check failed: next-cycle implication");

`endif

// ===== sv/mpt_pkg.sv =====
// shared constants, types and codes of the tachometer block
// no dependencies; imported by the interfaces and all modules
`default_nettype none

package mpt_pkg;

  // block dimensions
  localparam int CHANNELS     = 8;
  localparam int CAPTURE_BITS = 16;
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // field widths
  localparam int CHANNEL_W = 3;
  localparam int VALUE_W   = 16;
  localparam int SPEED_W   = 16;
  localparam int ACC_W     = 24;
  localparam int PAIR_W    = 8;
  localparam int DIVR_W    = 5;
  localparam int NUM_W     = 27;
  localparam int MULT_W    = 8;
  localparam int PROD_W    = NUM_W + MULT_W;
  localparam int SUM_W     = ((ACC_W > CAPTURE_BITS) ? ACC_W : CAPTURE_BITS) + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int MUL_CNT_W = $clog2(MULT_W + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NUM_W;

  // limits
  localparam logic [ACC_W-1:0]        ACC_MAX   = {ACC_W{1'b1}};
  localparam logic [SPEED_W-1:0]      SPEED_MAX = {SPEED_W{1'b1}};
  localparam logic [CAPTURE_BITS-1:0] CAP_MAX   = {CAPTURE_BITS{1'b1}};

  // register reset values
  localparam logic [PAIR_W-1:0] PAIRS_RESET = PAIR_W'(60);
  localparam logic [DIVR_W-1:0] DIVR_RESET  = DIVR_W'(10);
  localparam logic [NUM_W-1:0]  NUM_RESET   = NUM_W'(1000000);
  localparam logic [MULT_W-1:0] MULT_RESET  = MULT_W'(60);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAIRS   = 2'd0,
    REG_DIVISOR = 2'd1,
    REG_NUMER   = 2'd2,
    REG_MULT    = 2'd3
  } cfg_reg_t;

  // item operation codes
  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_EDGE_DIV,
    ST_TICK,
    ST_TICK_DIV,
    ST_TICK_MUL,
    ST_TICK_OUT
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [ACC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  // multiplier request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  a;
    logic [MULT_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== sv/mpt_if.sv =====
// valid/ready channel interfaces for capture items and speed results
// depends on mpt_pkg for field widths
`default_nettype none

interface mpt_req_if;
  import mpt_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [CHANNEL_W-1:0] channel;
  logic [VALUE_W-1:0]  capture_value;

  modport source (output valid, output op, output channel, output capture_value,
                  input ready);
  modport sink   (input valid, input op, input channel, input capture_value,
                  output ready);
endinterface

interface mpt_rsp_if;
  import mpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] out_channel;
  logic [SPEED_W-1:0]   speed;
  logic                 speed_valid;
  logic                 last;

  modport source (output valid, output out_channel, output speed, output speed_valid,
                  output last, input ready);
  modport sink   (input valid, input out_channel, input speed, input speed_valid,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== sv/mpt_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on mpt_pkg for widths and the request/response structs
`default_nettype none

module mpt_div (
  input  logic              clk,
  input  logic              rst,
  input  mpt_pkg::div_req_t req,
  output mpt_pkg::div_rsp_t rsp
);
  import mpt_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     quo;
  logic [ACC_W-1:0]     rem;
  logic [ACC_W-1:0]     dvs;
  logic [ACC_W:0]       rem_sh;
  logic [ACC_W:0]       trial;

  // shift in next dividend bit and try a subtract
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign trial  = rem_sh - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[ACC_W]) begin
        rem <= trial[ACC_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[ACC_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== sv/mpt_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle
// depends on mpt_pkg for widths and the request/response structs
`default_nettype none

module mpt_mul (
  input  logic              clk,
  input  logic              rst,
  input  mpt_pkg::mul_req_t req,
  output mpt_pkg::mul_rsp_t rsp
);
  import mpt_pkg::*;

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    a_sh;
  logic [MULT_W-1:0]    b_sh;
  logic [PROD_W-1:0]    acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MUL_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MULT_W);
      end else if (busy) begin
        cnt <= cnt - MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // add the shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sh <= PROD_W'(req.a);
      b_sh <= req.b;
      acc  <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= {a_sh[PROD_W-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[MULT_W-1:1]};
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

`default_nettype wire

// ===== sv/multichannel_pulse_tachometer.sv =====
// top level of the eight-channel input-capture tachometer
// depends on mpt_pkg, mpt_if, mpt_div, mpt_mul and the assertion header
//
//   port     dir   payload                                  transfer when
//   req      in    op, channel, capture_value               req.valid && req.ready
//   rsp      out   out_channel, speed, speed_valid, last    rsp.valid && rsp.ready
//   wr_*     in    wr_index, wr_data                        wr_en
//
// a capture edge passes through the edge state; an edge that closes a window then
// runs the divider and stores the quotient as the channel's window total.
// a tick runs the channels one after another: a channel with a zero total goes
// straight to the output state, otherwise it runs the divider, then the multiplier.
// one item is in work at a time; the output register lets the next item in while
// the last result of a tick waits. a stalled output holds the tick sequencer.
// reset is synchronous and clears all channel state but the first-edge store.
`default_nettype none

`include "multichannel_pulse_tachometer_assert.svh"

module multichannel_pulse_tachometer (
  input  logic                             clk,
  input  logic                             rst,
  mpt_req_if.sink                          req,
  mpt_rsp_if.source                        rsp,
  input  logic                             wr_en,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [mpt_pkg::CFG_DATA_W-1:0]   wr_data
);
  import mpt_pkg::*;

  // configuration registers
  logic [PAIR_W-1:0] pairs_per_window;
  logic [DIVR_W-1:0] window_divisor;
  logic [NUM_W-1:0]  speed_numerator;
  logic [MULT_W-1:0] speed_multiplier;

  // per-channel state
  logic                    pair_phase [CHANNELS];
  logic [CAPTURE_BITS-1:0] first_edge [CHANNELS];
  logic [ACC_W-1:0]        period_acc [CHANNELS];
  logic [PAIR_W-1:0]       pair_cnt   [CHANNELS];
  logic [ACC_W-1:0]        win_total  [CHANNELS];

  // sequencer
  state_t                  state, state_next;
  logic [CH_W-1:0]         cur;
  logic                    edge_ok;
  logic [CAPTURE_BITS-1:0] edge_val;
  logic [SPEED_W-1:0]      spd;
  logic                    spd_valid;

  // output register
  logic                 res_valid;
  logic [CHANNEL_W-1:0] res_channel;
  logic [SPEED_W-1:0]   res_speed;
  logic                 res_speed_valid;
  logic                 res_last;

  // arithmetic units
  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // edge datapath
  logic [CAPTURE_BITS-1:0] period;
  logic [SUM_W-1:0]        sum;
  logic [ACC_W-1:0]        sum_sat;
  logic [PAIR_W-1:0]       cnt_inc;
  logic                    win_close;
  logic [ACC_W-1:0]        divisor_eff;
  logic                    ch_last;
  logic                    out_load;
  logic                    accept;

  mpt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mpt_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_per_window <= PAIRS_RESET;
      window_divisor   <= DIVR_RESET;
      speed_numerator  <= NUM_RESET;
      speed_multiplier <= MULT_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_PAIRS:   pairs_per_window <= wr_data[PAIR_W-1:0];
        REG_DIVISOR: window_divisor   <= wr_data[DIVR_W-1:0];
        REG_NUMER:   speed_numerator  <= wr_data[NUM_W-1:0];
        REG_MULT:    speed_multiplier <= wr_data[MULT_W-1:0];
      endcase
    end
  end

  // period with wrap, saturating accumulate, pair count
  assign period  = (edge_val > first_edge[cur]) ? (edge_val - first_edge[cur])
                                                : ((CAP_MAX - first_edge[cur]) + edge_val);
  assign sum     = SUM_W'(period_acc[cur]) + SUM_W'(period);
  assign sum_sat = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
  assign cnt_inc   = pair_cnt[cur] + PAIR_W'(1);
  assign win_close = (cnt_inc == pairs_per_window);
  assign divisor_eff = (window_divisor == '0) ? ACC_W'(1) : ACC_W'(window_divisor);
  assign ch_last   = (cur == CH_W'(CHANNELS - 1));
  assign out_load  = (state == ST_TICK_OUT) && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit requests
  always_comb begin
    state_next       = state;
    req.ready        = (state == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = NUM_W'(sum_sat);
    div_req.divisor  = divisor_eff;
    mul_req.start    = 1'b0;
    mul_req.a        = div_rsp.quotient;
    mul_req.b        = speed_multiplier;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (op_t'(req.op) == OP_TICK) ? ST_TICK : ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (edge_ok && pair_phase[cur] && win_close) begin
          div_req.start = 1'b1;
          state_next    = ST_EDGE_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EDGE_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (win_total[cur] != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = speed_numerator;
          div_req.divisor  = win_total[cur];
          state_next       = ST_TICK_DIV;
        end else begin
          state_next = ST_TICK_OUT;
        end
      end
      ST_TICK_DIV: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          state_next    = ST_TICK_MUL;
        end
      end
      ST_TICK_MUL: begin
        if (mul_rsp.done) begin
          state_next = ST_TICK_OUT;
        end
      end
      ST_TICK_OUT: begin
        if (out_load) begin
          state_next = ch_last ? ST_IDLE : ST_TICK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // item latch, channel pointer and speed result
  always_ff @(posedge clk) begin
    if (accept) begin
      edge_val <= CAPTURE_BITS'(req.capture_value);
      edge_ok  <= (32'(req.channel) < CHANNELS);
      cur      <= (op_t'(req.op) == OP_TICK) ? '0 : CH_W'(req.channel);
    end else if (out_load && !ch_last) begin
      cur <= cur + CH_W'(1);
    end
    if (state == ST_TICK && win_total[cur] == '0) begin
      spd       <= '0;
      spd_valid <= 1'b0;
    end else if (state == ST_TICK_MUL && mul_rsp.done) begin
      spd       <= (|mul_rsp.product[PROD_W-1:SPEED_W]) ? SPEED_MAX
                                                        : mul_rsp.product[SPEED_W-1:0];
      spd_valid <= 1'b1;
    end
  end

  // first edge store, written before it is read
  always_ff @(posedge clk) begin
    if (state == ST_EDGE && edge_ok && !pair_phase[cur]) begin
      first_edge[cur] <= edge_val;
    end
  end

  // channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pair_phase[c] <= 1'b0;
        period_acc[c] <= '0;
        pair_cnt[c]   <= '0;
        win_total[c]  <= '0;
      end
    end else begin
      if (state == ST_EDGE && edge_ok) begin
        pair_phase[cur] <= !pair_phase[cur];
        if (pair_phase[cur]) begin
          if (win_close) begin
            period_acc[cur] <= '0;
            pair_cnt[cur]   <= '0;
          end else begin
            period_acc[cur] <= sum_sat;
            pair_cnt[cur]   <= cnt_inc;
          end
        end
      end
      if (state == ST_EDGE_DIV && div_rsp.done) begin
        win_total[cur] <= div_rsp.quotient[ACC_W-1:0];
      end
      if (out_load) begin
        win_total[cur] <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
    if (out_load) begin
      res_channel     <= CHANNEL_W'(cur);
      res_speed       <= spd;
      res_speed_valid <= spd_valid;
      res_last        <= ch_last;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.out_channel = res_channel;
  assign rsp.speed       = res_speed;
  assign rsp.speed_valid = res_speed_valid;
  assign rsp.last        = res_last;

  // checks
  `MPT_ASSERT_IMP(a_div_owner, clk, rst, div_rsp.busy, (state == ST_EDGE_DIV || state == ST_TICK_DIV))
  `MPT_ASSERT_IMP(a_mul_owner, clk, rst, mul_rsp.busy, state == ST_TICK_MUL)
  `MPT_ASSERT_IMP(a_zero_speed, clk, rst, rsp.valid && !rsp.speed_valid, rsp.speed == '0)
  `MPT_ASSERT_NXT(a_item_busy, clk, rst, accept, state != ST_IDLE)

endmodule

`default_nettype wire
